/* rtl/core/modbus_rtu_master_transaction_top_assert.svh */
// Assertion macros for the Modbus RTU master block.
`ifndef MODBUS_RTU_MASTER_TRANSACTION_TOP_ASSERT_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MRM_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define MRM_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define MRM_ASSERT_IMPL(label, a, c)
`define MRM_ASSERT_NEXT(label, a, c)
`endif
`endif

/* rtl/core/mrm_pkg.sv */
`default_nettype none
package mrm_pkg;
  localparam int MaxRegs = 125;
  localparam logic [2:0] CMD_READ = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_RX = 3'd2;
  localparam logic [2:0] CMD_TICK = 3'd3;
  localparam logic [2:0] CMD_FETCH = 3'd4;
  localparam logic [1:0] KIND_TX = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_WORD = 2'd2;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ARG = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_CRC = 3'd4;
  localparam logic [2:0] ST_BUSY = 3'd5;
  localparam logic [7:0] FN_READ = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h06;
  localparam logic [7:0] FN_EXC = 8'h83;
  localparam logic [7:0] MaxSlave = 8'd247;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  slave;
    logic [15:0] reg_address;
    logic [15:0] reg_count;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
    logic [6:0]  fetch_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
    logic [2:0]  status;
    logic        last;
  } out_word_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/mrm_frame_tx.sv */
`default_nettype none
module mrm_frame_tx (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [7:0]          b [6],
  output logic                     busy,
  output mrm_pkg::out_word_t       out_word,
  output logic                     out_valid,
  input  wire logic                out_ready
);
  logic [7:0] frame [6];
  logic [15:0] crc;
  logic [2:0] pos;
  logic [7:0] cur;

  assign busy = out_valid;
  assign cur = (pos < 3'd6) ? frame[pos] : (pos == 3'd6 ? crc[7:0] : crc[15:8]);
  assign out_word = '{kind: mrm_pkg::KIND_TX, data: {8'h00, cur},
                      status: mrm_pkg::ST_OK, last: (pos == 3'd7)};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos <= 3'd0;
    end else if (start) begin
      frame <= b;
      crc <= 16'hFFFF;
      pos <= 3'd0;
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      if (pos < 3'd6) begin
        crc <= mrm_pkg::crc_byte(crc, cur);
      end
      if (pos == 3'd7) begin
        out_valid <= 1'b0;
      end
      pos <= pos + 3'd1;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/modbus_rtu_master_transaction_top.sv */
// A request, fetch or status answer appears in the cycle after acceptance.
// Output: one word per cycle while out_ready is high; a request streams eight bytes
// from the frame transmitter, and the input waits until the last byte has left.
// A fetch reads the word memory through a registered read (mem_q).
// Reset: synchronous, active high; clears the phase and counters, timeout_ticks to 500.
`default_nettype none
module modbus_rtu_master_transaction_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mrm_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mrm_pkg::out_word_t      out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);
  typedef enum logic [1:0] {PH_IDLE, PH_READ, PH_WRITE, PH_WRITE_BAD} phase_t;

  logic [15:0] mem [mrm_pkg::MaxRegs];
  logic [15:0] mem_q;
  logic [15:0] timeout_ticks;
  phase_t phase;
  logic [7:0] exp_slave;
  logic [6:0] exp_words;
  logic [7:0] sent [6];
  logic [15:0] crc;
  logic [7:0] pos;
  logic [7:0] hi;
  logic [15:0] ticks;

  logic r_valid;
  mrm_pkg::out_word_t r_word;
  logic r_is_fetch;
  logic r_fetch_zero;

  logic tx_busy, tx_valid, tx_start;
  mrm_pkg::out_word_t tx_word;
  logic [7:0] tx_b [6];

  logic acc;
  logic [7:0] b;
  logic [8:0] nbytes;
  logic [15:0] crc_n;
  logic [15:0] rx_crc;
  logic req, bad_arg, st_fire;
  logic [2:0] st_code;
  logic wr_en;
  logic [6:0] wr_idx;
  logic [8:0] d;
  logic [15:0] ticks_inc;

  assign cfg_ready = 1'b1;
  assign in_ready = !tx_busy && !(r_valid && !out_ready);
  assign acc = in_valid && in_ready;
  assign b = in_word.rx_byte;
  assign nbytes = {1'b0, exp_words, 1'b0};
  assign crc_n = mrm_pkg::crc_byte(crc, b);
  assign rx_crc = {b, hi};
  assign d = {1'b0, pos} - 9'd3;
  assign ticks_inc = (ticks != 16'hFFFF) ? ticks + 16'd1 : ticks;
  assign req = in_word.cmd == mrm_pkg::CMD_READ || in_word.cmd == mrm_pkg::CMD_WRITE;
  assign bad_arg = in_word.slave == 8'd0 || in_word.slave > mrm_pkg::MaxSlave ||
                   (in_word.cmd == mrm_pkg::CMD_READ && (in_word.reg_count == 16'd0 ||
                    in_word.reg_count > 16'(mrm_pkg::MaxRegs)));
  assign tx_start = acc && req && phase == PH_IDLE && !bad_arg;

  always_comb begin
    tx_b[0] = in_word.slave;
    tx_b[1] = (in_word.cmd == mrm_pkg::CMD_READ) ? mrm_pkg::FN_READ : mrm_pkg::FN_WRITE;
    tx_b[2] = in_word.reg_address[15:8];
    tx_b[3] = in_word.reg_address[7:0];
    tx_b[4] = (in_word.cmd == mrm_pkg::CMD_READ) ? in_word.reg_count[15:8]
                                                 : in_word.write_value[15:8];
    tx_b[5] = (in_word.cmd == mrm_pkg::CMD_READ) ? in_word.reg_count[7:0]
                                                 : in_word.write_value[7:0];
  end

  always_comb begin
    st_fire = 1'b0;
    st_code = mrm_pkg::ST_OK;
    wr_en = 1'b0;
    wr_idx = d[7:1];
    if (acc) begin
      case (in_word.cmd)
        mrm_pkg::CMD_READ, mrm_pkg::CMD_WRITE: begin
          if (phase != PH_IDLE) begin
            st_fire = 1'b1;
            st_code = mrm_pkg::ST_BUSY;
          end else if (bad_arg) begin
            st_fire = 1'b1;
            st_code = mrm_pkg::ST_ARG;
          end
        end
        mrm_pkg::CMD_RX: begin
          if (phase == PH_READ) begin
            if ((pos == 8'd0 && b != exp_slave) ||
                (pos == 8'd1 && (b == mrm_pkg::FN_EXC || b != mrm_pkg::FN_READ)) ||
                (pos == 8'd2 && {1'b0, b} != nbytes)) begin
              st_fire = 1'b1;
              st_code = mrm_pkg::ST_INVALID;
            end else if ({1'b0, pos} < 9'd3 + nbytes) begin
              wr_en = pos >= 8'd3 && d[0];
            end else if ({1'b0, pos} != 9'd3 + nbytes) begin
              st_fire = 1'b1;
              st_code = (rx_crc != crc) ? mrm_pkg::ST_CRC : mrm_pkg::ST_OK;
            end
          end else if (phase != PH_IDLE) begin
            if ((pos[2:0] == 3'd0 && b != exp_slave) ||
                (pos[2:0] == 3'd1 && b != mrm_pkg::FN_WRITE)) begin
              st_fire = 1'b1;
              st_code = mrm_pkg::ST_INVALID;
            end else if (pos[2:0] == 3'd7) begin
              st_fire = 1'b1;
              st_code = (rx_crc != crc) ? mrm_pkg::ST_CRC :
                        (phase == PH_WRITE_BAD ? mrm_pkg::ST_INVALID : mrm_pkg::ST_OK);
            end
          end
        end
        mrm_pkg::CMD_TICK: begin
          if (phase != PH_IDLE && ticks_inc >= timeout_ticks) begin
            st_fire = 1'b1;
            st_code = mrm_pkg::ST_TIMEOUT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {hi, b};
    end
    if (acc && in_word.cmd == mrm_pkg::CMD_FETCH &&
        in_word.fetch_index < 7'(mrm_pkg::MaxRegs)) begin
      mem_q <= mem[in_word.fetch_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 16'd500;
      phase <= PH_IDLE;
      exp_slave <= 8'd0;
      exp_words <= 7'd0;
      crc <= 16'hFFFF;
      pos <= 8'd0;
      hi <= 8'd0;
      ticks <= 16'd0;
      r_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout_ticks <= cfg_data;
      end
      if (r_valid && out_ready) begin
        r_valid <= 1'b0;
      end
      if (st_fire || (acc && in_word.cmd == mrm_pkg::CMD_FETCH)) begin
        r_valid <= 1'b1;
        r_is_fetch <= !st_fire;
        r_fetch_zero <= in_word.fetch_index >= 7'(mrm_pkg::MaxRegs);
        r_word <= '{kind: mrm_pkg::KIND_STATUS, data: 16'd0, status: st_code, last: 1'b1};
      end
      if (st_fire && !req) begin
        phase <= PH_IDLE;
      end else if (tx_start) begin
        sent <= tx_b;
        exp_slave <= in_word.slave;
        exp_words <= (in_word.cmd == mrm_pkg::CMD_READ) ? in_word.reg_count[6:0] : 7'd0;
        phase <= (in_word.cmd == mrm_pkg::CMD_READ) ? PH_READ : PH_WRITE;
        crc <= 16'hFFFF;
        pos <= 8'd0;
        hi <= 8'd0;
        ticks <= 16'd0;
      end else if (acc && phase != PH_IDLE) begin
        if (in_word.cmd == mrm_pkg::CMD_TICK) begin
          ticks <= ticks_inc;
        end else if (in_word.cmd == mrm_pkg::CMD_RX) begin
          ticks <= 16'd0;
          if (phase == PH_READ) begin
            if ({1'b0, pos} < 9'd3 + nbytes) begin
              crc <= crc_n;
              if (pos >= 8'd3 && !d[0]) begin
                hi <= b;
              end
            end else begin
              hi <= b;
            end
            pos <= pos + 8'd1;
          end else begin
            if (pos[2:0] < 3'd6) begin
              crc <= crc_n;
              if (b != sent[pos[2:0]]) begin
                phase <= PH_WRITE_BAD;
              end
              pos <= {5'd0, pos[2:0]} + 8'd1;
            end else begin
              hi <= b;
              pos <= 8'd7;
            end
          end
        end
      end
    end
  end

  mrm_frame_tx u_tx (
    .clk(clk), .rst(rst), .start(tx_start), .b(tx_b), .busy(tx_busy),
    .out_word(tx_word), .out_valid(tx_valid), .out_ready(out_ready)
  );

  always_comb begin
    out_valid = r_valid || tx_valid;
    out_word = tx_word;
    if (r_valid) begin
      out_word = r_word;
      if (r_is_fetch) begin
        out_word.kind = mrm_pkg::KIND_WORD;
        out_word.data = r_fetch_zero ? 16'd0 : mem_q;
        out_word.status = mrm_pkg::ST_OK;
      end
    end
  end

`include "modbus_rtu_master_transaction_top_assert.svh"
  `MRM_ASSERT_IMPL(a_no_overlap, r_valid, !tx_valid)
  `MRM_ASSERT_NEXT(a_start_busy, tx_start, tx_busy && phase != PH_IDLE)
  `MRM_ASSERT_IMPL(a_tx_blocks, tx_busy, !in_ready)
endmodule
`default_nettype wire

/* test/modbus_rtu_master_transaction_top_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module modbus_rtu_master_transaction_top_tb;

  localparam int StallLimit = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  mrm_pkg::in_word_t in_word;
  logic out_valid;
  logic out_ready;
  mrm_pkg::out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  modbus_rtu_master_transaction_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  typedef enum logic [1:0] {
    PH_IDLE, PH_READ, PH_WRITE, PH_WRITE_BAD
  } link_phase_t;

  mrm_pkg::in_word_t pending_words[$];
  mrm_pkg::out_word_t expected_words_q[$];
  int errors;
  int quiet_cycles;
  bit idle_free;
  bit hold_off_req;
  int hold_off_left;
  bit in_fire;

  logic [15:0] m_timeout;
  link_phase_t m_phase;
  logic [7:0] m_slave;
  logic [7:0] m_function;
  logic [6:0] m_words;
  logic [7:0] m_frame[6];
  logic [15:0] m_crc;
  logic [7:0] m_pos;
  logic [7:0] m_high;
  logic [15:0] m_ticks;
  logic [15:0] m_store[mrm_pkg::MaxRegs];

  // Mirror of the stored words held on the stimulus side, so that in-range fetches
  // only address words that a read reply has already written.
  bit gen_written[mrm_pkg::MaxRegs];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic mrm_pkg::out_word_t mk(input logic [1:0] kind, input logic [15:0] data,
                                            input logic [2:0] st, input logic last);
    mrm_pkg::out_word_t w;
    w.kind = kind;
    w.data = data;
    w.status = st;
    w.last = last;
    return w;
  endfunction

  task automatic close_transaction(input logic [2:0] st);
    m_phase = PH_IDLE;
    expected_words_q.push_back(mk(mrm_pkg::KIND_STATUS, 16'h0, st, 1'b1));
  endtask

  task automatic predict_request(input mrm_pkg::in_word_t w);
    bit is_read;
    logic [15:0] operand;
    logic [15:0] crc;
    is_read = (w.cmd == mrm_pkg::CMD_READ);
    operand = is_read ? w.reg_count : w.write_value;
    if (m_phase != PH_IDLE) begin
      expected_words_q.push_back(mk(mrm_pkg::KIND_STATUS, 16'h0, mrm_pkg::ST_BUSY, 1'b1));
      return;
    end
    if (w.slave == 8'd0 || w.slave > mrm_pkg::MaxSlave ||
        (is_read && (w.reg_count == 16'd0 || w.reg_count > mrm_pkg::MaxRegs))) begin
      expected_words_q.push_back(mk(mrm_pkg::KIND_STATUS, 16'h0, mrm_pkg::ST_ARG, 1'b1));
      return;
    end
    m_frame[0] = w.slave;
    m_frame[1] = is_read ? mrm_pkg::FN_READ : mrm_pkg::FN_WRITE;
    m_frame[2] = w.reg_address[15:8];
    m_frame[3] = w.reg_address[7:0];
    m_frame[4] = operand[15:8];
    m_frame[5] = operand[7:0];
    crc = 16'hFFFF;
    for (int i = 0; i < 6; i++) begin
      crc = crc_step(crc, m_frame[i]);
      expected_words_q.push_back(mk(mrm_pkg::KIND_TX, {8'h00, m_frame[i]},
                                    mrm_pkg::ST_OK, 1'b0));
    end
    expected_words_q.push_back(mk(mrm_pkg::KIND_TX, {8'h00, crc[7:0]}, mrm_pkg::ST_OK, 1'b0));
    expected_words_q.push_back(mk(mrm_pkg::KIND_TX, {8'h00, crc[15:8]}, mrm_pkg::ST_OK, 1'b1));
    m_slave = w.slave;
    m_function = m_frame[1];
    m_words = is_read ? w.reg_count[6:0] : 7'd0;
    m_phase = is_read ? PH_READ : PH_WRITE;
    m_crc = 16'hFFFF;
    m_pos = 8'd0;
    m_high = 8'd0;
    m_ticks = 16'd0;
  endtask

  task automatic predict_read_byte(input logic [7:0] b);
    int pos;
    int nbytes;
    int d;
    pos = m_pos;
    nbytes = 2 * m_words;
    if (pos == 0 && b != m_slave) begin
      close_transaction(mrm_pkg::ST_INVALID);
    end else if (pos == 1 && (b == mrm_pkg::FN_EXC || b != m_function)) begin
      close_transaction(mrm_pkg::ST_INVALID);
    end else if (pos == 2 && b != nbytes) begin
      close_transaction(mrm_pkg::ST_INVALID);
    end else if (pos < 3 + nbytes) begin
      m_crc = crc_step(m_crc, b);
      if (pos >= 3) begin
        d = pos - 3;
        if (d % 2 == 0) m_high = b;
        else if (d / 2 < mrm_pkg::MaxRegs) m_store[d / 2] = {m_high, b};
      end
      m_pos = pos + 1;
    end else if (pos == 3 + nbytes) begin
      m_high = b;
      m_pos = pos + 1;
    end else if ({b, m_high} != m_crc) begin
      close_transaction(mrm_pkg::ST_CRC);
    end else begin
      close_transaction(mrm_pkg::ST_OK);
    end
  endtask

  task automatic predict_write_byte(input logic [7:0] b);
    int pos;
    pos = m_pos & 7;
    if ((pos == 0 && b != m_slave) || (pos == 1 && b != mrm_pkg::FN_WRITE)) begin
      close_transaction(mrm_pkg::ST_INVALID);
    end else if (pos < 6) begin
      m_crc = crc_step(m_crc, b);
      if (b != m_frame[pos]) m_phase = PH_WRITE_BAD;
      m_pos = pos + 1;
    end else if (pos == 6) begin
      m_high = b;
      m_pos = 8'd7;
    end else if ({b, m_high} != m_crc) begin
      close_transaction(mrm_pkg::ST_CRC);
    end else begin
      close_transaction(m_phase == PH_WRITE_BAD ? mrm_pkg::ST_INVALID : mrm_pkg::ST_OK);
    end
  endtask

  task automatic predict_word(input mrm_pkg::in_word_t w);
    case (w.cmd)
      mrm_pkg::CMD_READ, mrm_pkg::CMD_WRITE: begin
        predict_request(w);
      end
      mrm_pkg::CMD_RX: begin
        if (m_phase != PH_IDLE) begin
          m_ticks = 16'd0;
          if (m_phase == PH_READ) predict_read_byte(w.rx_byte);
          else predict_write_byte(w.rx_byte);
        end
      end
      mrm_pkg::CMD_TICK: begin
        if (m_phase != PH_IDLE) begin
          if (m_ticks < 16'hFFFF) m_ticks++;
          if (m_ticks >= m_timeout) close_transaction(mrm_pkg::ST_TIMEOUT);
        end
      end
      mrm_pkg::CMD_FETCH: begin
        expected_words_q.push_back(mk(mrm_pkg::KIND_WORD,
          w.fetch_index < mrm_pkg::MaxRegs ? m_store[w.fetch_index] : 16'h0,
          mrm_pkg::ST_OK, 1'b1));
      end
      default: begin
      end
    endcase
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_words.size() > 0 && (idle_free || $urandom_range(99) >= 21)) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_off_left <= 0;
    end else if (hold_off_req && hold_off_left == 0) begin
      hold_off_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= (hold_off_left == 1);
    end else begin
      out_ready <= idle_free || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) predict_word(in_word);
      if (out_valid && out_ready) begin
        if (expected_words_q.size() == 0) begin
          $error("unexpected word: kind %0d data %h status %0d last %0d",
                 out_word.kind, out_word.data, out_word.status, out_word.last);
          errors++;
        end else begin
          mrm_pkg::out_word_t e;
          e = expected_words_q.pop_front();
          if (e.kind !== out_word.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, out_word.kind);
            errors++;
          end
          if (e.data !== out_word.data) begin
            $error("data: expected %h actual %h", e.data, out_word.data);
            errors++;
          end
          if (e.status !== out_word.status) begin
            $error("status: expected %0d actual %0d", e.status, out_word.status);
            errors++;
          end
          if (e.last !== out_word.last) begin
            $error("last: expected %0d actual %0d", e.last, out_word.last);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
          $display("[modbus_rtu_master_transaction_top] ERROR");
          $finish;
        end
      end
    end
  end

  function automatic mrm_pkg::in_word_t blank_word(input logic [2:0] cmd);
    mrm_pkg::in_word_t w;
    w.cmd = cmd;
    w.slave = $urandom_range(255);
    w.reg_address = $urandom_range(65535);
    w.reg_count = $urandom_range(65535);
    w.write_value = $urandom_range(65535);
    w.rx_byte = $urandom_range(255);
    w.fetch_index = $urandom_range(127);
    return w;
  endfunction

  task automatic add_word(input mrm_pkg::in_word_t w);
    pending_words.push_back(w);
  endtask

  task automatic add_rx(input logic [7:0] b);
    mrm_pkg::in_word_t w;
    w = blank_word(mrm_pkg::CMD_RX);
    w.rx_byte = b;
    add_word(w);
  endtask

  task automatic add_ticks(input int n);
    for (int i = 0; i < n; i++) add_word(blank_word(mrm_pkg::CMD_TICK));
  endtask

  task automatic add_fetch(input int idx);
    mrm_pkg::in_word_t w;
    w = blank_word(mrm_pkg::CMD_FETCH);
    w.fetch_index = idx;
    add_word(w);
  endtask

  // A read request followed by its reply. fault picks the corruption:
  // none, wrong slave, exception function, wrong byte count, bad crc, or truncated.
  // A reply with a bad header is cut short to its first four bytes.
  task automatic add_read(input logic [7:0] slave, input int count, input int fault,
                          input logic [15:0] first);
    mrm_pkg::in_word_t w;
    logic [7:0] body[$];
    logic [15:0] crc;
    logic [15:0] v;
    w = blank_word(mrm_pkg::CMD_READ);
    w.slave = slave;
    w.reg_count = count;
    add_word(w);
    body.push_back(fault == 1 ? slave + 8'd1 : slave);
    body.push_back(fault == 2 ? mrm_pkg::FN_EXC : mrm_pkg::FN_READ);
    body.push_back(fault == 3 ? 8'(2 * count + 1) : 8'(2 * count));
    for (int i = 0; i < count; i++) begin
      v = (i == 0) ? first : 16'($urandom_range(65535));
      body.push_back(v[15:8]);
      body.push_back(v[7:0]);
    end
    crc = 16'hFFFF;
    foreach (body[i]) crc = crc_step(crc, body[i]);
    if (fault == 4) crc ^= 16'h1 << $urandom_range(15);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    if (fault == 5) body = body[0:$ - 3];
    if (fault >= 1 && fault <= 3) body = body[0:3];
    foreach (body[i]) begin
      add_rx(body[i]);
      if ($urandom_range(19) == 0) add_word(blank_word(mrm_pkg::CMD_TICK));
    end
    if (fault == 0) for (int i = 0; i < count; i++) gen_written[i] = 1'b1;
  endtask

  // A write request followed by its echo; fault: none, wrong slave, wrong function,
  // body mismatch, bad crc.
  task automatic add_write(input logic [7:0] slave, input logic [15:0] addr,
                           input logic [15:0] value, input int fault);
    mrm_pkg::in_word_t w;
    logic [7:0] body[$];
    logic [15:0] crc;
    w = blank_word(mrm_pkg::CMD_WRITE);
    w.slave = slave;
    w.reg_address = addr;
    w.write_value = value;
    add_word(w);
    body.push_back(fault == 1 ? ~slave : slave);
    body.push_back(fault == 2 ? mrm_pkg::FN_READ : mrm_pkg::FN_WRITE);
    body.push_back(addr[15:8]);
    body.push_back(addr[7:0]);
    body.push_back(value[15:8]);
    body.push_back(fault == 3 ? ~value[7:0] : value[7:0]);
    crc = 16'hFFFF;
    foreach (body[i]) crc = crc_step(crc, body[i]);
    if (fault == 4) crc ^= 16'h8000 >> $urandom_range(15);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    foreach (body[i]) add_rx(body[i]);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_words_q.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_timeout = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_random_traffic(input int n);
    int r;
    int written_max;
    mrm_pkg::in_word_t w;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        add_read($urandom_range(1, 247), $urandom_range(1, 4),
                 ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0,
                 16'($urandom_range(65535)));
      end else if (r < 60) begin
        add_write($urandom_range(1, 247), $urandom_range(65535), $urandom_range(65535),
                  ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
      end else if (r < 75) begin
        written_max = 0;
        while (written_max < mrm_pkg::MaxRegs && gen_written[written_max]) written_max++;
        w = blank_word(mrm_pkg::CMD_FETCH);
        if (w.fetch_index < mrm_pkg::MaxRegs && !gen_written[w.fetch_index])
          w.fetch_index = (written_max > 0 && $urandom_range(1)) ?
                          $urandom_range(written_max - 1) : 7'd125 + $urandom_range(2);
        add_word(w);
      end else if (r < 85) begin
        w = blank_word($urandom_range(1) ? mrm_pkg::CMD_READ : mrm_pkg::CMD_WRITE);
        add_word(w);
        add_ticks(3);
      end else if (r < 92) begin
        add_word(blank_word(mrm_pkg::CMD_RX));
      end else begin
        add_word(blank_word(3'($urandom_range(5, 7))));
        add_ticks(1);
      end
    end
  endtask

  initial begin
    errors = 0;
    quiet_cycles = 0;
    idle_free = 1'b0;
    hold_off_req = 1'b0;
    in_fire = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 16'h0;
    m_timeout = 16'd500;
    m_phase = PH_IDLE;
    m_slave = 8'h0;
    m_function = 8'h0;
    m_words = 7'h0;
    m_crc = 16'hFFFF;
    m_pos = 8'h0;
    m_high = 8'h0;
    m_ticks = 16'h0;
    foreach (m_frame[i]) m_frame[i] = 8'h0;
    foreach (m_store[i]) m_store[i] = 16'h0;
    foreach (gen_written[i]) gen_written[i] = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: argument limits, a full read, the fetch edges and idle traffic.
    add_read(8'd1, 125, 0, 16'hFFFF);
    add_read(8'd247, 1, 0, 16'h0000);
    add_fetch(0);
    add_fetch(124);
    add_fetch(127);
    add_word(blank_word(mrm_pkg::CMD_TICK));
    add_rx(8'hFF);
    add_word(blank_word(3'd7));
    begin
      mrm_pkg::in_word_t w;
      w = blank_word(mrm_pkg::CMD_READ); w.slave = 8'd0; w.reg_count = 16'd1; add_word(w);
      w = blank_word(mrm_pkg::CMD_READ); w.slave = 8'd248; w.reg_count = 16'd1; add_word(w);
      w = blank_word(mrm_pkg::CMD_READ); w.slave = 8'd5; w.reg_count = 16'd0; add_word(w);
      w = blank_word(mrm_pkg::CMD_READ); w.slave = 8'd5; w.reg_count = 16'd126; add_word(w);
      w = blank_word(mrm_pkg::CMD_WRITE); w.slave = 8'd255; add_word(w);
    end
    wait_drained();

    // Busy, every fault and the timeout.
    write_timeout(16'd3);
    begin
      mrm_pkg::in_word_t w;
      w = blank_word(mrm_pkg::CMD_WRITE); w.slave = 8'd9; add_word(w);
      w = blank_word(mrm_pkg::CMD_READ); w.slave = 8'd9; w.reg_count = 16'd2; add_word(w);
      add_ticks(3);
    end
    for (int f = 1; f <= 5; f++) add_read(8'd17, 2, f, 16'h1234);
    add_ticks(3);
    add_write(8'd1, 16'hFFFF, 16'h0000, 0);
    for (int f = 1; f <= 4; f++) add_write(8'd200, 16'h00FF, 16'hFF00, f);
    wait_drained();

    write_timeout(16'd1);
    add_random_traffic(4);
    wait_drained();

    write_timeout(16'd65535);
    add_write(8'd3, 16'h0, 16'h0, 0);
    idle_free = 1'b1;
    hold_off_req = 1'b1;
    add_random_traffic(5);
    wait_drained();
    hold_off_req = 1'b0;
    wait_drained();
    idle_free = 1'b0;

    write_timeout(16'd0);
    add_random_traffic(3);
    wait_drained();

    write_timeout(16'd4);
    add_random_traffic(3);
    wait_drained();

    if (errors == 0) begin
      $display("[modbus_rtu_master_transaction_top] OK");
    end else begin
      $display("[modbus_rtu_master_transaction_top] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* modbus_rtu_master_transaction_top.f */
+incdir+rtl/core
rtl/core/mrm_pkg.sv
rtl/core/mrm_frame_tx.sv
rtl/core/modbus_rtu_master_transaction_top.sv
test/modbus_rtu_master_transaction_top_tb.sv
